>>> rtl/bba_pkg.sv
// Package for the bitmap block allocator: widths, map geometry, operation and
// register codes, and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

   localparam int MAX_CONTROL_BYTES = 256;
   localparam int BLOCK_BYTES       = 16;

   localparam int FUNC_W   = 2;
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 15;
   localparam int OFFSET_W = 15;
   localparam int FREE_W   = 15;
   localparam int CB_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = CB_W;

   localparam int BLK_PER_ROW = 4;
   localparam int ENTRY_W     = 2;
   localparam int ROW_BITS    = BLK_PER_ROW * ENTRY_W;
   localparam int POS_W       = $clog2(BLK_PER_ROW);
   localparam int ROW_W       = $clog2(MAX_CONTROL_BYTES);
   localparam int ROWCNT_W    = $clog2(MAX_CONTROL_BYTES + 1);
   localparam int BLK_W       = ROW_W + POS_W;
   localparam int BLKCNT_W    = BLK_W + 1;
   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int NEED_W      = SIZE_W - BLOCK_SHIFT + 1;

   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 2'b00;
   localparam logic [ENTRY_W-1:0] ENTRY_USED = 2'b01;
   localparam logic [ENTRY_W-1:0] ENTRY_END  = 2'b11;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLED       = 1'd0,
      CSR_CONTROL_BYTES = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic mark_init;
      logic row_rd;
      logic mark_wr;
      logic free_wr;
      logic row_next;
      logic clear;
      logic finish;
      logic fin_ok;
   } cmd_type;

   typedef struct packed {
      logic     enabled;
      logic     need_zero;
      logic     free_in_range;
      logic     found;
      logic     scan_done;
      logic     mark_last;
      logic     free_done;
      func_type func;
   } status_type;

endpackage

>>> rtl/bba_ctrl.sv
// Controller for the bitmap block allocator: sequences scan, mark, free walk,
// clear and result hand-off. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [bba_pkg::FUNC_W-1:0] req_func,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bba_pkg::cmd_type    cmd,
   input  bba_pkg::status_type status
);
   import bba_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_FREE_RD,
      ST_FREE_WR,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ok_pend_ff, ok_pend_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      ok_pend_in = ok_pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               ok_pend_in = 1'b0;
               state_in   = ST_FINISH;
               if (status.enabled) begin
                  case (func_type'(req_func))
                     FUNC_ALLOC: begin
                        if (!status.need_zero) state_in = ST_SCAN;
                     end
                     FUNC_QUERY: state_in = ST_SCAN;
                     FUNC_FREE: begin
                        if (status.free_in_range) state_in = ST_FREE_RD;
                     end
                     FUNC_CLEAR: begin
                        cmd.clear  = 1'b1;
                        ok_pend_in = 1'b1;
                     end
                     default: state_in = ST_FINISH;
                  endcase
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.found) begin
               cmd.mark_init = 1'b1;
               state_in      = ST_MARK_RD;
            end else if (status.scan_done) begin
               ok_pend_in = (status.func == FUNC_QUERY);
               state_in   = ST_FINISH;
            end
         end
         ST_MARK_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            if (status.mark_last) begin
               ok_pend_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.row_next = 1'b1;
               state_in     = ST_MARK_RD;
            end
         end
         ST_FREE_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            cmd.free_wr = 1'b1;
            if (status.free_done) begin
               ok_pend_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.row_next = 1'b1;
               state_in     = ST_FREE_RD;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               cmd.fin_ok = ok_pend_ff;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ok_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ok_pend_ff   <= ok_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/bba_datapath.sv
// Datapath for the bitmap block allocator: configuration registers, block map
// memory with row valid bits, scan/mark/free row logic and result registers.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bba_pkg::cmd_type               cmd,
   output bba_pkg::status_type            status,
   input  logic [bba_pkg::FUNC_W-1:0]     req_func,
   input  logic [bba_pkg::SIZE_W-1:0]     req_size_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]     req_address,
   input  logic                           csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_ok,
   output logic [bba_pkg::OFFSET_W-1:0]   rsp_offset,
   output logic [bba_pkg::FREE_W-1:0]     rsp_free_bytes
);
   import bba_pkg::*;

   // configuration
   logic                enabled_ff;
   logic [CB_W-1:0]     ctl_bytes_ff;
   logic [ROWCNT_W-1:0] base;
   logic [BLKCNT_W-1:0] blocks;
   logic [ROW_W-1:0]    last_row;

   // map memory, one row per map byte
   logic [ROW_BITS-1:0] map_mem_ff [MAX_CONTROL_BYTES];
   logic                row_vld_ff [MAX_CONTROL_BYTES];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic                rd_vld_ff;
   logic [ROW_BITS-1:0] row_data;
   logic                rd_en;
   logic [ROW_W-1:0]    rd_addr;
   logic                wr_en;
   logic [ROW_BITS-1:0] wr_data;

   // item and walk state
   func_type            func_ff;
   logic [NEED_W-1:0]   need_ff;
   logic [NEED_W-1:0]   need_in;
   logic [ROWCNT_W-1:0] iss_ff;
   logic                iss_go;
   logic                pv_ff;
   logic [ROW_W-1:0]    proc_row_ff;
   logic [BLKCNT_W-1:0] run_ff;
   logic [BLKCNT_W-1:0] cnt_ff;
   logic [ROW_W-1:0]    cur_row_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [BLK_W-1:0]    start_blk_ff;
   logic [BLK_W-1:0]    end_blk_ff;
   logic [OFFSET_W-1:0] offset_ff;

   // free address decode
   logic [ADDR_W-1:0]   addr_diff;
   logic [BLKCNT_W-1:0] free_blk;

   // row logic
   logic [BLKCNT_W-1:0] run_v;
   logic [2:0]          free_cnt_v;
   logic                found_v;
   logic [POS_W-1:0]    pos_v;
   logic [BLK_W-1:0]    end_blk_v;
   logic [BLK_W-1:0]    start_blk_v;
   logic [ROW_BITS-1:0] mark_row;
   logic [ROW_BITS-1:0] free_row;
   logic                free_stop;

   // results
   logic                out_ok_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic [FREE_W-1:0]   out_free_ff;

   assign base     = (ctl_bytes_ff > CB_W'(MAX_CONTROL_BYTES)) ?
                     ROWCNT_W'(MAX_CONTROL_BYTES) : ctl_bytes_ff[ROWCNT_W-1:0];
   assign blocks   = {base, {POS_W{1'b0}}};
   assign last_row = ROW_W'(base - ROWCNT_W'(1));

   assign need_in   = NEED_W'(req_size_bytes >> BLOCK_SHIFT)
                    + NEED_W'(|req_size_bytes[BLOCK_SHIFT-1:0]);
   assign addr_diff = req_address - ADDR_W'(base);
   assign free_blk  = BLKCNT_W'(addr_diff >> BLOCK_SHIFT);

   assign iss_go  = cmd.scan && (iss_ff < base);
   assign rd_en   = iss_go || cmd.row_rd;
   assign rd_addr = cmd.row_rd ? cur_row_ff : iss_ff[ROW_W-1:0];
   assign wr_en   = cmd.mark_wr || cmd.free_wr;
   assign wr_data = cmd.mark_wr ? mark_row : free_row;

   assign row_data = rd_vld_ff ? rd_data_ff : '0;

   // first-fit run tracking and free count over one row
   always_comb begin
      run_v      = run_ff;
      free_cnt_v = '0;
      found_v    = 1'b0;
      pos_v      = '0;
      for (int j = 0; j < BLK_PER_ROW; j++) begin
         if (!row_data[j*ENTRY_W]) begin
            free_cnt_v = free_cnt_v + 3'd1;
            if (!found_v) begin
               run_v = run_v + BLKCNT_W'(1);
               if (NEED_W'(run_v) == need_ff) begin
                  found_v = 1'b1;
                  pos_v   = POS_W'(j);
               end
            end
         end else if (!found_v) begin
            run_v = '0;
         end
      end
   end

   assign end_blk_v   = {proc_row_ff, pos_v};
   assign start_blk_v = end_blk_v + BLK_W'(1) - BLK_W'(need_ff);

   // mark the run [start, end] in the current row
   always_comb begin
      logic [BLK_W-1:0] blk;
      mark_row = row_data;
      for (int j = 0; j < BLK_PER_ROW; j++) begin
         blk = {cur_row_ff, POS_W'(j)};
         if (blk == end_blk_ff) begin
            mark_row[j*ENTRY_W +: ENTRY_W] = ENTRY_END;
         end else if (blk >= start_blk_ff && blk < end_blk_ff) begin
            mark_row[j*ENTRY_W +: ENTRY_W] = row_data[j*ENTRY_W +: ENTRY_W] | ENTRY_USED;
         end
      end
   end

   // free walk over the current row
   always_comb begin
      logic [ENTRY_W-1:0] v;
      free_row  = row_data;
      free_stop = 1'b0;
      for (int j = 0; j < BLK_PER_ROW; j++) begin
         v = row_data[j*ENTRY_W +: ENTRY_W];
         if (POS_W'(j) >= pos_ff && !free_stop) begin
            if (v == ENTRY_FREE) begin
               free_stop = 1'b1;
            end else begin
               free_row[j*ENTRY_W +: ENTRY_W] = ENTRY_FREE;
               if (v == ENTRY_END) free_stop = 1'b1;
            end
         end
      end
   end

   always_comb begin
      status.enabled       = enabled_ff;
      status.need_zero     = (req_size_bytes == '0);
      status.free_in_range = (req_address >= ADDR_W'(base)) && (free_blk < blocks);
      status.found         = pv_ff && (func_ff == FUNC_ALLOC) && found_v;
      status.scan_done     = !pv_ff && (iss_ff >= base);
      status.mark_last     = (cur_row_ff == end_blk_ff[BLK_W-1:POS_W]);
      status.free_done     = free_stop || (cur_row_ff == last_row);
      status.func          = func_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         ctl_bytes_ff <= '0;
         iss_ff       <= '0;
         pv_ff        <= 1'b0;
         rd_vld_ff    <= 1'b0;
         for (int i = 0; i < MAX_CONTROL_BYTES; i++) row_vld_ff[i] <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ENABLED:       enabled_ff   <= csr_wdata[0];
               CSR_CONTROL_BYTES: ctl_bytes_ff <= csr_wdata[CB_W-1:0];
               default:           enabled_ff   <= enabled_ff;
            endcase
         end
         if (cmd.load) begin
            iss_ff <= '0;
            pv_ff  <= 1'b0;
         end else begin
            if (iss_go) iss_ff <= iss_ff + ROWCNT_W'(1);
            pv_ff <= iss_go;
         end
         if (rd_en) rd_vld_ff <= row_vld_ff[rd_addr];
         if (cmd.clear) begin
            for (int i = 0; i < MAX_CONTROL_BYTES; i++) row_vld_ff[i] <= 1'b0;
         end else if (wr_en) begin
            row_vld_ff[cur_row_ff] <= 1'b1;
         end
      end
   end

   // memory and payload registers
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= map_mem_ff[rd_addr];
      if (wr_en) map_mem_ff[cur_row_ff] <= wr_data;

      if (cmd.load) begin
         func_ff    <= func_type'(req_func);
         need_ff    <= need_in;
         run_ff     <= '0;
         cnt_ff     <= '0;
         cur_row_ff <= free_blk[BLK_W-1:POS_W];
         pos_ff     <= free_blk[POS_W-1:0];
      end else begin
         if (cmd.scan && pv_ff) begin
            run_ff <= run_v;
            cnt_ff <= cnt_ff + BLKCNT_W'(free_cnt_v);
         end
         if (cmd.mark_init) begin
            start_blk_ff <= start_blk_v;
            end_blk_ff   <= end_blk_v;
            cur_row_ff   <= start_blk_v[BLK_W-1:POS_W];
            offset_ff    <= OFFSET_W'(base) + (OFFSET_W'(start_blk_v) << BLOCK_SHIFT);
         end else if (cmd.row_next) begin
            cur_row_ff <= cur_row_ff + ROW_W'(1);
            pos_ff     <= '0;
         end
      end
      if (iss_go) proc_row_ff <= iss_ff[ROW_W-1:0];

      if (cmd.finish) begin
         out_ok_ff     <= cmd.fin_ok;
         out_offset_ff <= (cmd.fin_ok && func_ff == FUNC_ALLOC) ? offset_ff : '0;
         out_free_ff   <= (cmd.fin_ok && func_ff == FUNC_QUERY) ?
                          (FREE_W'(cnt_ff) << BLOCK_SHIFT) : '0;
      end
   end

   assign rsp_ok         = out_ok_ff;
   assign rsp_offset     = out_offset_ff;
   assign rsp_free_bytes = out_free_ff;

endmodule

>>> rtl/bitmap_block_allocator_top.sv
// Top level of the bitmap block allocator: joins controller and datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// First-fit allocator over a map of up to 1024 blocks of 16 bytes, stored
// as 256 map bytes of four 2-bit entries in a single-port row memory. Each
// item is handled alone; during a scan the map is read one row (four blocks)
// per cycle. A query, or an allocate that finds no room, scans control_bytes
// rows (control_bytes capped at 256); an allocate that finds room stops its
// scan at the row where the run ends and then reads and writes back each map
// row that the run touches. Free reads and writes back each row walked; clear
// and rejected items go straight to the result. A new item is taken as
// soon as the previous one has finished, even while its result still waits
// in the output register. Reset and clear empty the map at once through
// per-row valid bits; there is no clearing pass. Configuration is to be
// written only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps

module bitmap_block_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bba_pkg::FUNC_W-1:0]     req_func,
   input  logic [bba_pkg::SIZE_W-1:0]     req_size_bytes,
   input  logic [bba_pkg::ADDR_W-1:0]     req_address,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_ok,
   output logic [bba_pkg::OFFSET_W-1:0]   rsp_offset,
   output logic [bba_pkg::FREE_W-1:0]     rsp_free_bytes,
   input  logic                           csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bba_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bba_pkg::*;

   cmd_type    cmd;
   status_type status;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   bba_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_size_bytes (req_size_bytes),
      .req_address    (req_address),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_ok         (rsp_ok),
      .rsp_offset     (rsp_offset),
      .rsp_free_bytes (rsp_free_bytes)
   );

`ifndef SYNTHESIS
   // a result is never written over one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before taken");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in progress");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished item not presented");

   // failed items carry zero payload
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_offset == '0 && rsp_free_bytes == '0))
      else $error("failed item with nonzero payload");
`endif

endmodule
